// ===== sv/psic_pkg.sv =====
// ----------------------------------------------------------------------------
// Prefix set package
// Shared types, constants and prefix helper functions for the prefix set
// insert and cover lookup unit.
// ----------------------------------------------------------------------------
package psic_pkg;

    // Table size and field widths.
    localparam int TABLE_DEPTH = 64;
    localparam int ADDR_W      = 64;
    localparam int FULL_W      = 2 * ADDR_W;
    localparam int LEN_W       = 8;
    localparam int CNT_W       = 7;
    localparam int V4_WIDTH    = 32;
    localparam int V6_WIDTH    = 128;
    localparam int GRP_SIZE    = 8;
    localparam int GRP_CNT_W   = 4;

    // Transaction kinds.
    localparam logic ACT_ADD    = 1'b0;
    localparam logic ACT_SEARCH = 1'b1;

    // Sequencer states.
    typedef enum logic [1:0] {
        S_IDLE,
        S_CMP,
        S_DEC,
        S_WR
    } t_state;

    // Control and query broadcast from the sequencer to every cell.
    typedef struct packed {
        logic                 cmp;
        logic                 remove;
        logic                 write;
        logic                 is_v6;
        logic [LEN_W-1:0]     len;
        logic [FULL_W-1:0]    addr;
        logic [FULL_W-1:0]    mask;
    } t_cell_ctl;

    // Clamp a prefix length to the width of its address version.
    function automatic logic [LEN_W-1:0] clamp_len(input logic v6, input logic [LEN_W-1:0] len);
        logic [LEN_W-1:0] res;
        res = len;
        if (v6 && len > LEN_W'(V6_WIDTH)) begin
            res = LEN_W'(V6_WIDTH);
        end else if (!v6 && len > LEN_W'(V4_WIDTH)) begin
            res = LEN_W'(V4_WIDTH);
        end
        return res;
    endfunction

    // Mask of the first len address bits; an IPv4 mask lives in bits 31..0.
    function automatic logic [FULL_W-1:0] prefix_mask(input logic v6,
                                                      input logic [LEN_W-1:0] len);
        logic [FULL_W-1:0]   m6;
        logic [V4_WIDTH-1:0] m4;
        m6 = ~({FULL_W{1'b1}} >> len);
        m4 = ~({V4_WIDTH{1'b1}} >> len);
        return v6 ? m6 : {{(FULL_W - V4_WIDTH){1'b0}}, m4};
    endfunction

endpackage

// ===== sv/prefix_set_insert_and_cover_lookup_unit.sv =====
// ----------------------------------------------------------------------------
// Prefix set insert and cover lookup unit
// Keeps a set of non-nesting IPv4/IPv6 prefixes in a row of cells; adds
// prefixes and answers whether a query is covered by a stored prefix.
// ----------------------------------------------------------------------------
// Each transaction runs these steps in order from acceptance to a registered
// result: load and mask the query, let every cell compare it with its slot,
// decide cover and drop the narrower prefixes an add replaces, then claim the
// lowest free cell and form the result, waiting there while the output stalls.
// One transaction is in flight at a time; the next is accepted in the cycle after
// the result is registered, even while that result is still stalled on the output.
// The free-slot search ripples once along the row of TABLE_DEPTH cells, and
// the removed count is summed from registered groups of eight cells.
module prefix_set_insert_and_cover_lookup_unit #(
    parameter int TABLE_DEPTH = psic_pkg::TABLE_DEPTH
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic                          i_action,
    input  logic                          i_is_v6,
    input  logic [psic_pkg::ADDR_W-1:0]   i_addr_high,
    input  logic [psic_pkg::ADDR_W-1:0]   i_addr_low,
    input  logic [psic_pkg::LEN_W-1:0]    i_prefix_len,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic                          o_ok,
    output logic                          o_table_full,
    output logic [psic_pkg::CNT_W-1:0]    o_removed_count
);

    localparam int NGRP = (TABLE_DEPTH + psic_pkg::GRP_SIZE - 1) / psic_pkg::GRP_SIZE;
    localparam int CW   = $clog2(TABLE_DEPTH + 1);
    localparam int SW   = (CW > psic_pkg::CNT_W) ? CW : psic_pkg::CNT_W;
    localparam int CMAX = (1 << psic_pkg::CNT_W) - 1;

    psic_pkg::t_state                 r_state, n_state;
    logic                             r_action;
    logic                             r_is_v6;
    logic [psic_pkg::LEN_W-1:0]       r_len;
    logic [psic_pkg::FULL_W-1:0]      r_addr;
    logic [psic_pkg::FULL_W-1:0]      r_mask;
    logic                             r_covered;
    logic [psic_pkg::GRP_CNT_W-1:0]   r_grp [NGRP];
    logic                             r_out_valid;
    logic                             r_ok;
    logic                             r_full;
    logic [psic_pkg::CNT_W-1:0]       r_removed;

    psic_pkg::t_cell_ctl              w_ctl;
    logic [TABLE_DEPTH:0]             w_free;
    logic [TABLE_DEPTH-1:0]           w_take;
    logic [TABLE_DEPTH-1:0]           w_cover;
    logic [TABLE_DEPTH-1:0]           w_inside;
    logic [NGRP*psic_pkg::GRP_SIZE-1:0] w_inside_pad;
    logic [psic_pkg::GRP_CNT_W-1:0]   n_grp [NGRP];
    logic [SW-1:0]                    n_sum;
    logic [psic_pkg::CNT_W-1:0]       n_removed;
    logic                             w_accept;
    logic                             w_out_free;
    logic                             w_is_add;
    logic                             w_any_cover;
    logic [psic_pkg::LEN_W-1:0]       w_len_clamp;
    logic [psic_pkg::FULL_W-1:0]      w_mask_in;

    // Handshake.
    assign o_stall    = (r_state != psic_pkg::S_IDLE);
    assign w_accept   = i_valid && !o_stall;
    assign w_out_free = !r_out_valid || !i_stall;
    assign w_is_add   = (r_action == psic_pkg::ACT_ADD);
    assign w_any_cover = |w_cover;

    // Clamp and mask the incoming query.
    assign w_len_clamp = psic_pkg::clamp_len(i_is_v6, i_prefix_len);
    assign w_mask_in   = psic_pkg::prefix_mask(i_is_v6, w_len_clamp);

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_action <= i_action;
            r_is_v6  <= i_is_v6;
            r_len    <= w_len_clamp;
            r_mask   <= w_mask_in;
            r_addr   <= {i_addr_high, i_addr_low} & w_mask_in;
        end
    end

    // Sequencer state register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= psic_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and broadcast control to the cell row.
    always_comb begin
        n_state      = r_state;
        w_ctl.cmp    = 1'b0;
        w_ctl.remove = 1'b0;
        w_ctl.write  = 1'b0;
        w_ctl.is_v6  = r_is_v6;
        w_ctl.len    = r_len;
        w_ctl.addr   = r_addr;
        w_ctl.mask   = r_mask;
        case (r_state)
            psic_pkg::S_IDLE: begin
                if (w_accept) begin
                    n_state = psic_pkg::S_CMP;
                end
            end
            psic_pkg::S_CMP: begin
                w_ctl.cmp = 1'b1;
                n_state   = psic_pkg::S_DEC;
            end
            psic_pkg::S_DEC: begin
                w_ctl.remove = w_is_add && !w_any_cover;
                n_state      = psic_pkg::S_WR;
            end
            psic_pkg::S_WR: begin
                w_ctl.write = w_is_add && !r_covered && w_out_free;
                if (w_out_free) begin
                    n_state = psic_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = psic_pkg::S_IDLE;
            end
        endcase
    end

    // Row of cells with the free-slot chain between neighbors.
    assign w_free[0] = 1'b0;

    for (genvar gi = 0; gi < TABLE_DEPTH; gi++) begin : g_cell
        psic_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_ctl      (w_ctl),
            .i_free_in  (w_free[gi]),
            .o_free_out (w_free[gi+1]),
            .o_take     (w_take[gi]),
            .o_cover    (w_cover[gi]),
            .o_inside   (w_inside[gi])
        );
    end

    // Count removed prefixes in groups of eight cells.
    always_comb begin
        w_inside_pad = '0;
        w_inside_pad[TABLE_DEPTH-1:0] = w_inside;
        for (int g = 0; g < NGRP; g++) begin
            n_grp[g] = '0;
            for (int j = 0; j < psic_pkg::GRP_SIZE; j++) begin
                n_grp[g] = n_grp[g]
                    + psic_pkg::GRP_CNT_W'(w_inside_pad[g*psic_pkg::GRP_SIZE + j]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == psic_pkg::S_DEC) begin
            r_covered <= w_any_cover;
            for (int g = 0; g < NGRP; g++) begin
                r_grp[g] <= w_ctl.remove ? n_grp[g] : '0;
            end
        end
    end

    // Total removed count, saturated to the field width.
    always_comb begin
        n_sum = '0;
        for (int g = 0; g < NGRP; g++) begin
            n_sum = n_sum + SW'(r_grp[g]);
        end
        n_removed = (n_sum > SW'(CMAX)) ? psic_pkg::CNT_W'(CMAX) : n_sum[psic_pkg::CNT_W-1:0];
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == psic_pkg::S_WR && w_out_free) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == psic_pkg::S_WR && w_out_free) begin
            if (w_is_add) begin
                r_ok      <= !r_covered && w_free[TABLE_DEPTH];
                r_full    <= !r_covered && !w_free[TABLE_DEPTH];
                r_removed <= n_removed;
            end else begin
                r_ok      <= r_covered;
                r_full    <= 1'b0;
                r_removed <= '0;
            end
        end
    end

    assign o_valid         = r_out_valid;
    assign o_ok            = r_ok;
    assign o_table_full    = r_full;
    assign o_removed_count = r_removed;

    // At most one cell claims a new prefix.
    a_single_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_take))
        else $error("more than one cell claimed the new prefix");

    // A covered add never writes a cell.
    a_covered_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == psic_pkg::S_WR && r_covered) |-> (w_take == '0))
        else $error("covered prefix was written to the table");

    // A result is never both stored and rejected for lack of space.
    a_ok_full_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_ok && o_table_full))
        else $error("result reports both stored and table full");

endmodule

// ===== sv/psic_cell.sv =====
// ----------------------------------------------------------------------------
// Prefix set cell
// One table slot: holds a stored prefix, compares it against the broadcast
// query, and takes part in the free-slot chain that runs along the row.
// ----------------------------------------------------------------------------
module psic_cell (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  psic_pkg::t_cell_ctl  i_ctl,
    input  logic                 i_free_in,
    output logic                 o_free_out,
    output logic                 o_take,
    output logic                 o_cover,
    output logic                 o_inside
);

    logic                          r_valid;
    logic                          r_is_v6;
    logic [psic_pkg::LEN_W-1:0]    r_len;
    logic [psic_pkg::FULL_W-1:0]   r_addr;
    logic                          r_cover;
    logic                          r_inside;

    logic [psic_pkg::FULL_W-1:0]   w_mask;
    logic                          w_same;
    logic                          n_cover;
    logic                          n_inside;

    // Compare the stored prefix with the query in both directions.
    always_comb begin
        w_mask   = psic_pkg::prefix_mask(r_is_v6, r_len);
        w_same   = r_valid && (r_is_v6 == i_ctl.is_v6);
        n_cover  = w_same && (r_len <= i_ctl.len) && ((i_ctl.addr & w_mask) == r_addr);
        n_inside = w_same && (r_len > i_ctl.len) && ((r_addr & i_ctl.mask) == i_ctl.addr);
    end

    // The lowest free cell in the row claims the new prefix.
    assign o_free_out = i_free_in | ~r_valid;
    assign o_take     = i_ctl.write & ~r_valid & ~i_free_in;
    assign o_cover    = r_cover;
    assign o_inside   = r_inside;

    // Control state: occupancy and compare flags.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= 1'b0;
            r_cover  <= 1'b0;
            r_inside <= 1'b0;
        end else begin
            if (i_ctl.cmp) begin
                r_cover  <= n_cover;
                r_inside <= n_inside;
            end
            if (i_ctl.remove && r_inside) begin
                r_valid <= 1'b0;
            end
            if (o_take) begin
                r_valid <= 1'b1;
            end
        end
    end

    // Stored prefix, loaded when this cell is claimed.
    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_is_v6 <= i_ctl.is_v6;
            r_len   <= i_ctl.len;
            r_addr  <= i_ctl.addr;
        end
    end

endmodule

// ===== verif/tb_prefix_set_insert_and_cover_lookup_unit.sv =====
// ----------------------------------------------------------------------------
// Prefix set insert and cover lookup unit testbench
// Drives add and search transactions into the unit and predicts every
// result with a local copy of the prefix table. The sequence fills the
// table to overflow, walks the corner cases, runs random traffic in
// prefix regions under several idle patterns, holds the result side off
// for a long stretch, and ends with zero-length prefixes.
// ----------------------------------------------------------------------------
module tb_prefix_set_insert_and_cover_lookup_unit;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_PERIOD     = 20;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int HOLD_CYCLES    = 300;
    localparam int ROOTS          = 4;
    localparam int PHASE_ITEMS    = 265;

    typedef enum logic [1:0] {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } t_idle_mode;

    typedef struct packed {
        logic                        action;
        logic                        is_v6;
        logic [psic_pkg::ADDR_W-1:0] addr_high;
        logic [psic_pkg::ADDR_W-1:0] addr_low;
        logic [psic_pkg::LEN_W-1:0]  prefix_len;
    } t_prefix_op;

    typedef struct packed {
        logic                       ok;
        logic                       table_full;
        logic [psic_pkg::CNT_W-1:0] removed_count;
    } t_set_result;

    // Ports of the unit.
    logic                          i_clk;
    logic                          i_rst_n;
    logic                          i_valid;
    logic                          o_stall;
    logic                          i_action;
    logic                          i_is_v6;
    logic [psic_pkg::ADDR_W-1:0]   i_addr_high;
    logic [psic_pkg::ADDR_W-1:0]   i_addr_low;
    logic [psic_pkg::LEN_W-1:0]    i_prefix_len;
    logic                          o_valid;
    logic                          i_stall;
    logic                          o_ok;
    logic                          o_table_full;
    logic [psic_pkg::CNT_W-1:0]    o_removed_count;

    // Local copy of the prefix table.
    logic                          set_used [psic_pkg::TABLE_DEPTH];
    logic                          set_v6   [psic_pkg::TABLE_DEPTH];
    logic [psic_pkg::FULL_W-1:0]   set_key  [psic_pkg::TABLE_DEPTH];
    logic [psic_pkg::FULL_W-1:0]   set_mask [psic_pkg::TABLE_DEPTH];
    int unsigned                   set_len  [psic_pkg::TABLE_DEPTH];

    t_set_result                   pending_results [$];
    int unsigned                   error_count;
    int unsigned                   stuck_cycles = 0;
    int unsigned                   send_idle_pct;
    int unsigned                   recv_stall_pct;
    int unsigned                   hold_requests;

    // Address regions of the current random phase.
    logic [31:0]                   root_v4 [ROOTS];
    logic [psic_pkg::ADDR_W-1:0]   root_v6 [ROOTS];
    logic [7:0]                    region_v4;
    logic [15:0]                   region_v6;

    prefix_set_insert_and_cover_lookup_unit DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_action        (i_action),
        .i_is_v6         (i_is_v6),
        .i_addr_high     (i_addr_high),
        .i_addr_low      (i_addr_low),
        .i_prefix_len    (i_prefix_len),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_ok            (o_ok),
        .o_table_full    (o_table_full),
        .o_removed_count (o_removed_count)
    );

    initial i_clk = 1'b0;
    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    function automatic logic [psic_pkg::ADDR_W-1:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // Network mask with the first len address bits set; IPv4 sits in bits 31..0.
    function automatic logic [psic_pkg::FULL_W-1:0] lead_ones(logic v6, int unsigned len);
        logic [psic_pkg::FULL_W-1:0] m;
        int                          top;
        m   = '0;
        top = v6 ? psic_pkg::FULL_W - 1 : psic_pkg::V4_WIDTH - 1;
        for (int b = 0; b < len; b++) begin
            m[top - b] = 1'b1;
        end
        return m;
    endfunction

    // Applies one transaction to the local table and returns its result.
    function automatic t_set_result apply_prefix_op(t_prefix_op op);
        t_set_result                 res;
        int unsigned                 width;
        int unsigned                 len;
        int unsigned                 removed;
        int                          free_slot;
        logic                        covered;
        logic [psic_pkg::FULL_W-1:0] qmask;
        logic [psic_pkg::FULL_W-1:0] qkey;
        res     = '0;
        removed = 0;
        width   = op.is_v6 ? psic_pkg::V6_WIDTH : psic_pkg::V4_WIDTH;
        len     = (op.prefix_len > width) ? width : op.prefix_len;
        qmask   = lead_ones(op.is_v6, len);
        qkey    = {(op.is_v6 ? op.addr_high : {psic_pkg::ADDR_W{1'b0}}), op.addr_low} & qmask;

        // Covered by an equal or wider prefix of the same version.
        covered = 1'b0;
        for (int s = 0; s < psic_pkg::TABLE_DEPTH; s++) begin
            if (set_used[s] && set_v6[s] == op.is_v6 && set_len[s] <= len &&
                (qkey & set_mask[s]) == set_key[s]) begin
                covered = 1'b1;
            end
        end

        if (op.action == psic_pkg::ACT_SEARCH) begin
            res.ok = covered;
        end else if (!covered) begin
            // Drop every narrower prefix inside the new one.
            for (int s = 0; s < psic_pkg::TABLE_DEPTH; s++) begin
                if (set_used[s] && set_v6[s] == op.is_v6 && set_len[s] > len &&
                    (set_key[s] & qmask) == qkey) begin
                    set_used[s] = 1'b0;
                    removed++;
                end
            end
            free_slot = -1;
            for (int s = psic_pkg::TABLE_DEPTH - 1; s >= 0; s--) begin
                if (!set_used[s]) begin
                    free_slot = s;
                end
            end
            if (free_slot >= 0) begin
                set_used[free_slot] = 1'b1;
                set_v6[free_slot]   = op.is_v6;
                set_key[free_slot]  = qkey;
                set_mask[free_slot] = qmask;
                set_len[free_slot]  = len;
                res.ok              = 1'b1;
            end else begin
                res.table_full = 1'b1;
            end
            res.removed_count = (removed > 127) ? psic_pkg::CNT_W'(127)
                                                : psic_pkg::CNT_W'(removed);
        end
        return res;
    endfunction

    function automatic t_prefix_op make_op(logic act, logic v6,
                                           logic [psic_pkg::ADDR_W-1:0] hi,
                                           logic [psic_pkg::ADDR_W-1:0] lo,
                                           logic [psic_pkg::LEN_W-1:0] len);
        t_prefix_op op;
        op.action     = act;
        op.is_v6      = v6;
        op.addr_high  = hi;
        op.addr_low   = lo;
        op.prefix_len = len;
        return op;
    endfunction

    function automatic void set_idle(t_idle_mode mode);
        case (mode)
            IDLE_NONE: begin
                send_idle_pct  = 0;
                recv_stall_pct = 0;
            end
            IDLE_SENDER: begin
                send_idle_pct  = 84;
                recv_stall_pct = 0;
            end
            IDLE_RECEIVER: begin
                send_idle_pct  = 0;
                recv_stall_pct = 84;
            end
            default: begin
                send_idle_pct  = 30;
                recv_stall_pct = 30;
            end
        endcase
    endfunction

    // Picks a fresh /8 (IPv4) and /16 (IPv6) region; the top three bits keep
    // regions of different phases apart.
    function automatic void pick_region(int unsigned region);
        region_v4 = {3'(region), 5'($urandom)};
        region_v6 = {3'(region), 13'($urandom)};
        for (int r = 0; r < ROOTS; r++) begin
            root_v4[r] = {region_v4, 24'($urandom)};
            root_v6[r] = {region_v6, 48'(rand64())};
        end
    endfunction

    // Mostly prefixes near the region roots, so that adds overlap, cover and
    // replace each other; a few stray searches anywhere.
    function automatic t_prefix_op random_op();
        t_prefix_op  op;
        int unsigned r;
        int unsigned sh;
        logic [31:0] jitter;
        op.action    = $urandom_range(1) ? psic_pkg::ACT_SEARCH : psic_pkg::ACT_ADD;
        op.is_v6     = 1'($urandom_range(1));
        op.addr_high = rand64();
        op.addr_low  = rand64();
        r            = $urandom_range(ROOTS - 1);
        if ($urandom_range(99) < 5) begin
            op.action     = psic_pkg::ACT_SEARCH;
            op.prefix_len = psic_pkg::LEN_W'($urandom_range(255));
        end else if (!op.is_v6) begin
            sh                = $urandom_range(20);
            jitter            = $urandom;
            op.addr_low[31:0] = root_v4[r] ^ (jitter & ((32'd1 << sh) - 32'd1));
            op.prefix_len     = ($urandom_range(99) < 15)
                                ? psic_pkg::LEN_W'($urandom_range(255, 33))
                                : psic_pkg::LEN_W'($urandom_range(32, 12));
        end else begin
            sh            = $urandom_range(40);
            op.addr_high  = root_v6[r] ^ (rand64() & ((64'd1 << sh) - 64'd1));
            op.prefix_len = ($urandom_range(99) < 15)
                            ? psic_pkg::LEN_W'($urandom_range(255, 129))
                            : psic_pkg::LEN_W'($urandom_range(128, 24));
        end
        return op;
    endfunction

    // Offers one transaction after a random gap and returns at the falling
    // edge that follows its acceptance.
    task automatic send_op(t_prefix_op op);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid      <= 1'b1;
        i_action     <= op.action;
        i_is_v6      <= op.is_v6;
        i_addr_high  <= op.addr_high;
        i_addr_low   <= op.addr_low;
        i_prefix_len <= op.prefix_len;
        @(posedge i_clk);
        while (o_stall) begin
            @(posedge i_clk);
        end
        pending_results = {pending_results, apply_prefix_op(op)};
        @(negedge i_clk);
    endtask

    // Stops offering and waits until every predicted result has come back.
    task automatic wait_all_results();
        i_valid <= 1'b0;
        do begin
            @(negedge i_clk);
        end while (pending_results.size() != 0);
    endtask

    // Wide prefixes over the current region sweep out what the phase stored.
    task automatic clear_region();
        send_op(make_op(psic_pkg::ACT_ADD, 1'b0, rand64(),
                        {$urandom, region_v4, 24'($urandom)}, 8'd8));
        send_op(make_op(psic_pkg::ACT_ADD, 1'b1, {region_v6, 48'(rand64())}, rand64(), 8'd16));
    endtask

    // Fill every slot with distinct host routes, overflow, then sweep them all.
    task automatic test_table_full();
        set_idle(IDLE_NONE);
        for (int i = 0; i < psic_pkg::TABLE_DEPTH; i++) begin
            send_op(make_op(psic_pkg::ACT_ADD, 1'b0, rand64(),
                            {$urandom, 8'hE5, 18'($urandom), 6'(i)}, 8'd32));
        end
        send_op(make_op(psic_pkg::ACT_ADD, 1'b1, rand64(), rand64(), 8'd128));
        send_op(make_op(psic_pkg::ACT_SEARCH, 1'b0, '0, {32'd0, 8'hE5, 24'd0}, 8'd8));
        send_op(make_op(psic_pkg::ACT_ADD, 1'b0, '0, {32'hFFFF_FFFF, 8'hE5, 24'hFF_FFFF}, 8'd8));
        wait_all_results();
    endtask

    task automatic test_directed_cases();
        set_idle(IDLE_NONE);
        // Basic add, then a covered query with junk in the ignored bits.
        send_op(make_op(psic_pkg::ACT_ADD, 1'b0, '0, 64'h0000_0000_0A00_0000, 8'd8));
        send_op(make_op(psic_pkg::ACT_SEARCH, 1'b0, '1, 64'hFFFF_FFFF_0A01_0203, 8'd32));
        // The same bits as an IPv6 query are never covered by IPv4.
        send_op(make_op(psic_pkg::ACT_SEARCH, 1'b1, '0, 64'h0000_0000_0A01_0203, 8'd128));
        // Narrower and equal adds are rejected as covered.
        send_op(make_op(psic_pkg::ACT_ADD, 1'b0, '0, 64'h0000_0000_0A01_0000, 8'd16));
        send_op(make_op(psic_pkg::ACT_ADD, 1'b0, '1, 64'h0000_0000_0A00_0000, 8'd8));
        // Over-long IPv4 lengths clamp to a host route.
        send_op(make_op(psic_pkg::ACT_ADD, 1'b0, '0, 64'h0000_0000_0B02_0304, 8'd255));
        send_op(make_op(psic_pkg::ACT_SEARCH, 1'b0, '0, 64'h0000_0000_0B02_0304, 8'd33));
        send_op(make_op(psic_pkg::ACT_SEARCH, 1'b0, '0, 64'h0000_0000_0B02_0305, 8'd32));
        send_op(make_op(psic_pkg::ACT_SEARCH, 1'b0, '1, 64'hFFFF_FFFF_0B02_0304, 8'd100));
        // A zero-length query is not covered by longer prefixes.
        send_op(make_op(psic_pkg::ACT_SEARCH, 1'b0, '1, '1, 8'd0));
        // IPv6 host route with an over-long length, and a /64.
        send_op(make_op(psic_pkg::ACT_ADD, 1'b1, '1, '1, 8'd200));
        send_op(make_op(psic_pkg::ACT_ADD, 1'b1, 64'hFD00_0DB8_0000_0001, '1, 8'd64));
        send_op(make_op(psic_pkg::ACT_SEARCH, 1'b1, 64'hFD00_0DB8_0000_0001, '0, 8'd129));
        send_op(make_op(psic_pkg::ACT_SEARCH, 1'b1, '1, '1, 8'd127));
        send_op(make_op(psic_pkg::ACT_SEARCH, 1'b1, '1, '1, 8'd128));
        // A wider IPv6 add replaces the /64 below it.
        send_op(make_op(psic_pkg::ACT_ADD, 1'b1, 64'hFD00_0DB8_0000_0000, '0, 8'd32));
        send_op(make_op(psic_pkg::ACT_SEARCH, 1'b1, 64'hFD00_0DB8_FFFF_FFFF, '1, 8'd48));
        wait_all_results();
    endtask

    task automatic test_random_phase(t_idle_mode mode, int unsigned region, int count);
        set_idle(mode);
        pick_region(region);
        for (int i = 0; i < count; i++) begin
            send_op(random_op());
        end
        clear_region();
        wait_all_results();
    endtask

    // The result side holds off while transactions keep coming, so the unit
    // backs up and stalls its input.
    task automatic test_output_holdoff();
        set_idle(IDLE_NONE);
        pick_region(5);
        hold_requests++;
        for (int i = 0; i < 30; i++) begin
            send_op(random_op());
        end
        clear_region();
        wait_all_results();
    endtask

    // Zero-length prefixes cover a whole version; they stay for good, so last.
    task automatic test_zero_length();
        set_idle(IDLE_BOTH);
        send_op(make_op(psic_pkg::ACT_SEARCH, 1'b0, rand64(), rand64(), 8'd0));
        send_op(make_op(psic_pkg::ACT_ADD, 1'b0, '1, '1, 8'd0));
        send_op(make_op(psic_pkg::ACT_ADD, 1'b1, rand64(), rand64(), 8'd0));
        send_op(make_op(psic_pkg::ACT_SEARCH, 1'b0, rand64(), rand64(), 8'd32));
        send_op(make_op(psic_pkg::ACT_SEARCH, 1'b1, rand64(), rand64(), 8'd255));
        send_op(make_op(psic_pkg::ACT_ADD, 1'b0, rand64(), rand64(), 8'd24));
        send_op(make_op(psic_pkg::ACT_ADD, 1'b1, '0, '0, 8'd0));
        wait_all_results();
    endtask

    // Result side: random stall per mode, or a long hold when one is requested.
    initial begin : result_receiver
        int unsigned holds_done;
        holds_done = 0;
        i_stall    = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_requests != holds_done) begin
                holds_done++;
                for (int n = 0; n < HOLD_CYCLES; n++) begin
                    i_stall <= 1'b1;
                    @(negedge i_clk);
                end
            end
            i_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    // Compare each accepted result with the oldest prediction.
    always @(posedge i_clk) begin : result_check
        t_set_result want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_results.size() == 0) begin
                error_count++;
                $display("%0t: unexpected result ok=%0b full=%0b removed=%0d",
                         $time, o_ok, o_table_full, o_removed_count);
            end else begin
                want = pending_results.pop_front();
                if (o_ok !== want.ok || o_table_full !== want.table_full ||
                    o_removed_count !== want.removed_count) begin
                    error_count++;
                    $display("%0t: mismatch ok/full/removed expected %0b/%0b/%0d got %0b/%0b/%0d",
                             $time, want.ok, want.table_full, want.removed_count,
                             o_ok, o_table_full, o_removed_count);
                end
            end
        end
    end

    // Give up when neither side has moved a transaction for too long.
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
            stuck_cycles <= 0;
        end else begin
            stuck_cycles <= stuck_cycles + 1;
        end
        if (stuck_cycles >= WATCHDOG_LIMIT) begin
            $display("** prefix_set_insert_and_cover_lookup_unit: FAILED **");
            $finish;
        end
    end

    initial begin : test_sequence
        i_rst_n        = 1'b0;
        i_valid        = 1'b0;
        i_action       = psic_pkg::ACT_ADD;
        i_is_v6        = 1'b0;
        i_addr_high    = '0;
        i_addr_low     = '0;
        i_prefix_len   = '0;
        error_count    = 0;
        hold_requests  = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        for (int s = 0; s < psic_pkg::TABLE_DEPTH; s++) begin
            set_used[s] = 1'b0;
        end

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_table_full();
        test_directed_cases();
        test_random_phase(IDLE_NONE, 1, PHASE_ITEMS);
        test_random_phase(IDLE_SENDER, 2, PHASE_ITEMS);
        test_random_phase(IDLE_RECEIVER, 3, PHASE_ITEMS);
        test_random_phase(IDLE_BOTH, 4, PHASE_ITEMS);
        test_output_holdoff();
        test_zero_length();

        // Let any stray result arrive before the verdict.
        repeat (10) @(negedge i_clk);
        if (error_count == 0) begin
            $display("** prefix_set_insert_and_cover_lookup_unit: PASSED **");
        end else begin
            $display("** prefix_set_insert_and_cover_lookup_unit: FAILED **");
        end
        $finish;
    end

endmodule
